### src/index_pool_allocator_defines.svh
// Assertion macros shared by the index pool allocator RTL.
`ifndef INDEX_POOL_ALLOCATOR_DEFINES_SVH
`define INDEX_POOL_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS

`define IPA_ASSERT_SAME(label, clk, rst, cond, expect_now) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expect_now)) \
      else $error("index_pool_allocator: same-cycle check failed");

`define IPA_ASSERT_NEXT(label, clk, rst, cond, expect_next) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expect_next)) \
      else $error("index_pool_allocator: next-cycle check failed");

`else

`define IPA_ASSERT_SAME(label, clk, rst, cond, expect_now)

`define IPA_ASSERT_NEXT(label, clk, rst, cond, expect_next)

`endif

`endif

### src/ipa_pkg.sv
// Types and codes shared by the index pool allocator modules.
`timescale 1ns / 1ps

package ipa_pkg;

   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_SET   = 2'd2,
      OP_GET   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_INVALID = 2'd2
   } status_type;

   typedef struct packed {
      logic load;
      logic exec;
   } ctrl_cmd_type;

endpackage

### src/ipa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ipa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/ipa_ctrl.sv
// Controller state machine: sequences capture and execute of one request beat.
`timescale 1ns / 1ps

module ipa_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   output logic                  rsp_strobe,
   output ipa_pkg::ctrl_cmd_type cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff;
   logic      busy_ff;
   logic      strobe_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         busy_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               strobe_ff <= 1'b0;
               if (start) begin
                  state_ff <= ST_EXEC;
                  busy_ff  <= 1'b1;
               end
            end
            ST_EXEC: begin
               state_ff  <= ST_IDLE;
               busy_ff   <= 1'b0;
               strobe_ff <= 1'b1;
            end
         endcase
      end
   end

   assign busy       = busy_ff;
   assign rsp_strobe = strobe_ff;
   assign cmd.load   = start && !busy_ff;
   assign cmd.exec   = (state_ff == ST_EXEC);

endmodule

### src/ipa_datapath.sv
// Datapath: pool registers, free-list pointers, node and link RAMs, result beat.
`timescale 1ns / 1ps

module ipa_datapath #(
   parameter int POOL_DEPTH   = 1024,
   parameter int PAYLOAD_BITS = 32,
   parameter int IDX_W        = $clog2(POOL_DEPTH),
   parameter int CNT_W        = IDX_W + 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ipa_pkg::ctrl_cmd_type cmd,
   input  logic [1:0]            req_operation,
   input  logic [IDX_W-1:0]      req_node_index,
   input  logic [PAYLOAD_BITS-1:0] req_payload,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CNT_W-1:0]      csr_wdata,
   output logic [1:0]            rsp_status,
   output logic [IDX_W-1:0]      rsp_granted_index,
   output logic [PAYLOAD_BITS-1:0] rsp_read_payload
);

   localparam int NODE_W = PAYLOAD_BITS + 1;
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(POOL_DEPTH);

   ipa_pkg::op_type        op_ff;
   logic [IDX_W-1:0]       idx_ff;
   logic [PAYLOAD_BITS-1:0] word_ff;

   logic [CNT_W-1:0]       pool_size_ff;
   logic [CNT_W-1:0]       high_water_ff, high_water_in;
   logic [IDX_W-1:0]       free_head_ff, free_head_in;
   logic [IDX_W-1:0]       free_tail_ff, free_tail_in;
   logic                   free_empty_ff, free_empty_in;

   ipa_pkg::status_type    status_ff, status_in;
   logic [IDX_W-1:0]       grant_ff, grant_in;
   logic [PAYLOAD_BITS-1:0] rdp_ff, rdp_in;

   logic                   node_we;
   logic [IDX_W-1:0]       node_wa;
   logic [NODE_W-1:0]      node_wd;
   logic [NODE_W-1:0]      node_rd;
   logic                   link_we;
   logic [IDX_W-1:0]       link_wa;
   logic [IDX_W-1:0]       link_wd;
   logic [IDX_W-1:0]       link_rd;

   logic [CNT_W-1:0]       limit;
   logic                   addressable;

   ipa_ram #(.WIDTH(NODE_W), .DEPTH(POOL_DEPTH)) u_node_ram (
      .clock   (clock),
      .wr_en   (node_we),
      .wr_addr (node_wa),
      .wr_data (node_wd),
      .rd_en   (cmd.load),
      .rd_addr (req_node_index),
      .rd_data (node_rd)
   );

   ipa_ram #(.WIDTH(IDX_W), .DEPTH(POOL_DEPTH)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_wa),
      .wr_data (link_wd),
      .rd_en   (cmd.load),
      .rd_addr (free_head_ff),
      .rd_data (link_rd)
   );

   assign limit       = (pool_size_ff > DEPTH_CNT) ? DEPTH_CNT : pool_size_ff;
   assign addressable = ({1'b0, idx_ff} < high_water_ff) && node_rd[PAYLOAD_BITS];

   always_comb begin
      high_water_in = high_water_ff;
      free_head_in  = free_head_ff;
      free_tail_in  = free_tail_ff;
      free_empty_in = free_empty_ff;
      status_in     = ipa_pkg::STATUS_OK;
      grant_in      = '0;
      rdp_in        = '0;
      node_we       = 1'b0;
      node_wa       = idx_ff;
      node_wd       = '0;
      link_we       = 1'b0;
      link_wa       = free_tail_ff;
      link_wd       = idx_ff;
      if (cmd.exec) begin
         unique case (op_ff)
            ipa_pkg::OP_ALLOC: begin
               if (!free_empty_ff) begin
                  grant_in = free_head_ff;
                  node_we  = 1'b1;
                  node_wa  = free_head_ff;
                  node_wd  = {1'b1, {PAYLOAD_BITS{1'b0}}};
                  if (free_head_ff == free_tail_ff) begin
                     free_empty_in = 1'b1;
                  end else begin
                     free_head_in = link_rd;
                  end
               end else if (high_water_ff < limit) begin
                  grant_in      = high_water_ff[IDX_W-1:0];
                  node_we       = 1'b1;
                  node_wa       = high_water_ff[IDX_W-1:0];
                  node_wd       = {1'b1, {PAYLOAD_BITS{1'b0}}};
                  high_water_in = high_water_ff + CNT_W'(1);
               end else begin
                  status_in = ipa_pkg::STATUS_FULL;
               end
            end
            ipa_pkg::OP_FREE: begin
               if (!addressable) begin
                  status_in = ipa_pkg::STATUS_INVALID;
               end else begin
                  node_we      = 1'b1;
                  node_wd      = '0;
                  free_tail_in = idx_ff;
                  if (free_empty_ff) begin
                     free_head_in  = idx_ff;
                     free_empty_in = 1'b0;
                  end else begin
                     link_we = 1'b1;
                  end
               end
            end
            ipa_pkg::OP_SET: begin
               if (!addressable) begin
                  status_in = ipa_pkg::STATUS_INVALID;
               end else begin
                  node_we = 1'b1;
                  node_wd = {1'b1, word_ff};
               end
            end
            ipa_pkg::OP_GET: begin
               if (!addressable) begin
                  status_in = ipa_pkg::STATUS_INVALID;
               end else begin
                  rdp_in = node_rd[PAYLOAD_BITS-1:0];
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_size_ff  <= DEPTH_CNT;
         high_water_ff <= '0;
         free_head_ff  <= '0;
         free_tail_ff  <= '0;
         free_empty_ff <= 1'b1;
      end else begin
         if (csr_valid && csr_ready) begin
            pool_size_ff <= csr_wdata;
         end
         high_water_ff <= high_water_in;
         free_head_ff  <= free_head_in;
         free_tail_ff  <= free_tail_in;
         free_empty_ff <= free_empty_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= ipa_pkg::op_type'(req_operation);
         idx_ff  <= req_node_index;
         word_ff <= req_payload;
      end
      if (cmd.exec) begin
         status_ff <= status_in;
         grant_ff  <= grant_in;
         rdp_ff    <= rdp_in;
      end
   end

   assign csr_ready         = 1'b1;
   assign rsp_status        = status_ff;
   assign rsp_granted_index = grant_ff;
   assign rsp_read_payload  = rdp_ff;

endmodule

### src/index_pool_allocator.sv
// Top level of the index pool allocator: controller, datapath and checks.
//
//   channel  ports                         handshake
//   request  req_operation/node_index/payload  start && !busy
//   result   rsp_status/granted_index/read_payload  rsp_strobe, one cycle
//   config   csr_wdata (pool_size)         csr_valid && csr_ready
//
// A request is captured with the node and link RAM reads, then executed on
// the registered read data. busy is high in the execute cycle; the result
// beat follows in the next cycle, when a new request may already be
// captured. Reset is synchronous; no clearing pass.
// The result receiver never stalls; csr_ready is always high.
`timescale 1ns / 1ps
`include "index_pool_allocator_defines.svh"

module index_pool_allocator #(
   parameter int POOL_DEPTH   = 1024,
   parameter int PAYLOAD_BITS = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [1:0]                         req_operation,
   input  logic [$clog2(POOL_DEPTH)-1:0]      req_node_index,
   input  logic [PAYLOAD_BITS-1:0]            req_payload,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [$clog2(POOL_DEPTH):0]        csr_wdata,
   output logic                               rsp_strobe,
   output logic [1:0]                         rsp_status,
   output logic [$clog2(POOL_DEPTH)-1:0]      rsp_granted_index,
   output logic [PAYLOAD_BITS-1:0]            rsp_read_payload
);

   localparam int IDX_W = $clog2(POOL_DEPTH);
   localparam int CNT_W = IDX_W + 1;

   ipa_pkg::ctrl_cmd_type cmd;

   ipa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   ipa_datapath #(
      .POOL_DEPTH   (POOL_DEPTH),
      .PAYLOAD_BITS (PAYLOAD_BITS),
      .IDX_W        (IDX_W),
      .CNT_W        (CNT_W)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_operation     (req_operation),
      .req_node_index    (req_node_index),
      .req_payload       (req_payload),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_wdata         (csr_wdata),
      .rsp_status        (rsp_status),
      .rsp_granted_index (rsp_granted_index),
      .rsp_read_payload  (rsp_read_payload)
   );

   `IPA_ASSERT_NEXT(a_accept_sets_busy, clock, reset, cmd.load, busy && cmd.exec)
   `IPA_ASSERT_NEXT(a_exec_gives_beat, clock, reset, cmd.exec, rsp_strobe && !busy)
   `IPA_ASSERT_SAME(a_beat_not_busy, clock, reset, rsp_strobe, !busy && !cmd.exec)
   `IPA_ASSERT_SAME(a_fail_zero_fields, clock, reset, rsp_strobe && (rsp_status != ipa_pkg::STATUS_OK), (rsp_granted_index == '0) && (rsp_read_payload == '0))

endmodule

### sim/index_pool_checker.sv
// Checker for the index pool allocator: predicts every result beat and compares it.
`timescale 1ns / 1ps

module index_pool_checker #(
   parameter int POOL_DEPTH   = 1024,
   parameter int PAYLOAD_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic [1:0]                    req_operation,
   input  logic [$clog2(POOL_DEPTH)-1:0] req_node_index,
   input  logic [PAYLOAD_BITS-1:0]       req_payload,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [$clog2(POOL_DEPTH):0]   csr_wdata,
   input  logic                          rsp_strobe,
   input  logic [1:0]                    rsp_status,
   input  logic [$clog2(POOL_DEPTH)-1:0] rsp_granted_index,
   input  logic [PAYLOAD_BITS-1:0]       rsp_read_payload,
   output int                            error_count,
   output int                            outstanding
);

   localparam int IDX_W = $clog2(POOL_DEPTH);

   typedef struct packed {
      ipa_pkg::status_type     status;
      logic [IDX_W-1:0]        granted;
      logic [PAYLOAD_BITS-1:0] word;
   } pool_reply_type;

   logic [IDX_W-1:0]        link_mem [POOL_DEPTH];
   logic [PAYLOAD_BITS-1:0] word_mem [POOL_DEPTH];
   bit                      in_use   [POOL_DEPTH];
   logic [IDX_W:0]          high_water_mark;
   logic [IDX_W-1:0]        list_head;
   logic [IDX_W-1:0]        list_tail;
   bit                      list_empty;
   logic [IDX_W:0]          pool_size_reg;
   pool_reply_type          reply_q [$];

   function automatic pool_reply_type predict_pool_op(input ipa_pkg::op_type op,
                                                      input logic [IDX_W-1:0] idx,
                                                      input logic [PAYLOAD_BITS-1:0] word);
      pool_reply_type   reply;
      int unsigned      cap;
      logic [IDX_W-1:0] pick;
      reply = '{status: ipa_pkg::STATUS_OK, granted: '0, word: '0};
      cap = (pool_size_reg < POOL_DEPTH) ? pool_size_reg : POOL_DEPTH;
      if (op == ipa_pkg::OP_ALLOC) begin
         if (!list_empty) begin
            pick = list_head;
            if (list_head == list_tail) list_empty = 1'b1;
            else list_head = link_mem[pick];
         end else if (high_water_mark < cap) begin
            pick = high_water_mark[IDX_W-1:0];
            high_water_mark++;
         end else begin
            reply.status = ipa_pkg::STATUS_FULL;
            return reply;
         end
         in_use[pick] = 1'b1;
         word_mem[pick] = '0;
         reply.granted = pick;
      end else if (idx >= high_water_mark || !in_use[idx]) begin
         reply.status = ipa_pkg::STATUS_INVALID;
      end else if (op == ipa_pkg::OP_FREE) begin
         in_use[idx] = 1'b0;
         if (list_empty) begin
            list_head = idx;
            list_tail = idx;
            list_empty = 1'b0;
         end else begin
            link_mem[list_tail] = idx;
            list_tail = idx;
         end
      end else if (op == ipa_pkg::OP_SET) begin
         word_mem[idx] = word;
      end else begin
         reply.word = word_mem[idx];
      end
      return reply;
   endfunction

   always @(posedge clock) begin : monitor
      pool_reply_type exp_reply;
      if (reset) begin
         for (int n = 0; n < POOL_DEPTH; n++) in_use[n] = 1'b0;
         high_water_mark = '0;
         list_head = '0;
         list_tail = '0;
         list_empty = 1'b1;
         pool_size_reg = (IDX_W + 1)'(POOL_DEPTH);
         reply_q.delete();
         error_count = 0;
         outstanding = 0;
      end else begin
         if (rsp_strobe) begin
            if (reply_q.size() == 0) begin
               $error("result beat with no request outstanding");
               error_count++;
            end else begin
               exp_reply = reply_q.pop_front();
               if (rsp_status !== exp_reply.status) begin
                  $error("status mismatch: expected %0d, actual %0d",
                         exp_reply.status, rsp_status);
                  error_count++;
               end
               if (rsp_granted_index !== exp_reply.granted) begin
                  $error("granted_index mismatch: expected %0d, actual %0d",
                         exp_reply.granted, rsp_granted_index);
                  error_count++;
               end
               if (rsp_read_payload !== exp_reply.word) begin
                  $error("read_payload mismatch: expected %h, actual %h",
                         exp_reply.word, rsp_read_payload);
                  error_count++;
               end
            end
         end
         if (csr_valid && csr_ready) pool_size_reg = csr_wdata;
         if (start && !busy) begin
            reply_q.push_back(predict_pool_op(ipa_pkg::op_type'(req_operation),
                                              req_node_index, req_payload));
         end
         outstanding = reply_q.size();
      end
   end

endmodule

### sim/testbench.sv
// Top of the index pool allocator testbench: clock, reset, stimulus phases and verdict.
`timescale 1ns / 1ps

module testbench;

   localparam int POOL_DEPTH     = 1024;
   localparam int PAYLOAD_BITS   = 32;
   localparam int IDX_W          = $clog2(POOL_DEPTH);
   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 5000;

   logic                    clock          = 1'b0;
   logic                    reset          = 1'b1;
   logic                    start          = 1'b0;
   logic                    busy;
   logic [1:0]              req_operation  = '0;
   logic [IDX_W-1:0]        req_node_index = '0;
   logic [PAYLOAD_BITS-1:0] req_payload    = '0;
   logic                    csr_valid      = 1'b0;
   logic                    csr_ready;
   logic [IDX_W:0]          csr_wdata      = '0;
   logic                    rsp_strobe;
   logic [1:0]              rsp_status;
   logic [IDX_W-1:0]        rsp_granted_index;
   logic [PAYLOAD_BITS-1:0] rsp_read_payload;
   int                      error_count;
   int                      outstanding;
   int                      idle_pct = 0;

   always #5 clock = ~clock;

   index_pool_allocator #(
      .POOL_DEPTH  (POOL_DEPTH),
      .PAYLOAD_BITS(PAYLOAD_BITS)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_operation    (req_operation),
      .req_node_index   (req_node_index),
      .req_payload      (req_payload),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_wdata        (csr_wdata),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_granted_index(rsp_granted_index),
      .rsp_read_payload (rsp_read_payload)
   );

   index_pool_checker #(
      .POOL_DEPTH  (POOL_DEPTH),
      .PAYLOAD_BITS(PAYLOAD_BITS)
   ) i_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_operation    (req_operation),
      .req_node_index   (req_node_index),
      .req_payload      (req_payload),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_wdata        (csr_wdata),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_granted_index(rsp_granted_index),
      .rsp_read_payload (rsp_read_payload),
      .error_count      (error_count),
      .outstanding      (outstanding)
   );

   task automatic issue_request(input ipa_pkg::op_type op, input logic [IDX_W-1:0] idx,
                                input logic [PAYLOAD_BITS-1:0] word);
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      start          <= 1'b1;
      req_operation  <= op;
      req_node_index <= idx;
      req_payload    <= word;
      do @(posedge clock); while (busy);
   endtask

   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_pool_size(input logic [IDX_W:0] size);
      drain_results();
      csr_valid <= 1'b1;
      csr_wdata <= size;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic run_random_phase(input int items, input int alloc_pct, input int idx_span);
      ipa_pkg::op_type         op;
      logic [IDX_W-1:0]        idx;
      logic [PAYLOAD_BITS-1:0] word;
      for (int n = 0; n < items; n++) begin
         // hold off now and then until every result is back
         if ($urandom_range(99) < 2) drain_results();
         if ($urandom_range(99) < alloc_pct) op = ipa_pkg::OP_ALLOC;
         else op = ipa_pkg::op_type'($urandom_range(3, 1));
         if ($urandom_range(9) == 0) idx = IDX_W'($urandom_range(POOL_DEPTH - 1));
         else idx = IDX_W'($urandom_range(idx_span));
         case ($urandom_range(7))
            0: word = '0;
            1: word = '1;
            2: word = 32'h7FFF_FFFF;
            3: word = 32'h8000_0000;
            default: word = $urandom;
         endcase
         issue_request(op, idx, word);
      end
   endtask

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : stimulus
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      idle_pct = 0;
      write_pool_size(0);
      issue_request(ipa_pkg::OP_ALLOC, 10'd0, 32'h0);
      issue_request(ipa_pkg::OP_GET, 10'd0, 32'h0);
      write_pool_size(1);
      issue_request(ipa_pkg::OP_ALLOC, 10'd0, 32'h0);
      issue_request(ipa_pkg::OP_ALLOC, 10'd0, 32'h0);
      issue_request(ipa_pkg::OP_SET, 10'd0, 32'hFFFF_FFFF);
      issue_request(ipa_pkg::OP_GET, 10'd0, 32'h0);
      issue_request(ipa_pkg::OP_SET, 10'd0, 32'h7FFF_FFFF);
      issue_request(ipa_pkg::OP_GET, 10'd0, 32'h0);
      issue_request(ipa_pkg::OP_SET, 10'd0, 32'h8000_0000);
      issue_request(ipa_pkg::OP_GET, 10'd0, 32'hFFFF_FFFF);
      issue_request(ipa_pkg::OP_FREE, 10'd0, 32'h0);
      issue_request(ipa_pkg::OP_FREE, 10'd0, 32'h0);
      issue_request(ipa_pkg::OP_GET, 10'd0, 32'h0);
      issue_request(ipa_pkg::OP_SET, 10'd0, 32'h1234_5678);
      issue_request(ipa_pkg::OP_ALLOC, 10'd0, 32'h0);
      issue_request(ipa_pkg::OP_GET, 10'd0, 32'h0);
      issue_request(ipa_pkg::OP_FREE, 10'd1023, 32'h0);
      issue_request(ipa_pkg::OP_SET, 10'd1023, 32'hFFFF_FFFF);
      issue_request(ipa_pkg::OP_GET, 10'd1023, 32'h0);
      write_pool_size(2);
      issue_request(ipa_pkg::OP_ALLOC, 10'd0, 32'h0);
      issue_request(ipa_pkg::OP_FREE, 10'd1, 32'h0);
      issue_request(ipa_pkg::OP_FREE, 10'd0, 32'h0);
      issue_request(ipa_pkg::OP_ALLOC, 10'd0, 32'h0);
      issue_request(ipa_pkg::OP_ALLOC, 10'd0, 32'h0);
      issue_request(ipa_pkg::OP_ALLOC, 10'd0, 32'h0);

      write_pool_size(16);
      idle_pct = 0;
      run_random_phase(60, 35, 17);

      write_pool_size(64);
      idle_pct = 67;
      run_random_phase(60, 35, 66);

      // fill the whole pool, past its end
      write_pool_size(2047);
      idle_pct = 33;
      run_random_phase(1030, 100, POOL_DEPTH - 1);

      write_pool_size(4);
      idle_pct = 67;
      run_random_phase(80, 20, POOL_DEPTH - 1);

      write_pool_size(1024);
      idle_pct = 0;
      run_random_phase(40, 40, POOL_DEPTH - 1);

      drain_results();
      if (error_count == 0 && outstanding == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+src
src/ipa_pkg.sv
src/ipa_ram.sv
src/ipa_ctrl.sv
src/ipa_datapath.sv
src/index_pool_allocator.sv
sim/index_pool_checker.sv
sim/testbench.sv
